// ===== rtl/salct_pkg.sv =====
// ----------------------------------------------------------------------------
// salct_pkg: shared definitions for the set-associative LRU tag cache
// Address split, request record passed from front to back, back-end states.
// ----------------------------------------------------------------------------
package salct_pkg;

  // Address geometry
  localparam int unsigned AddrW     = 32;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned LineBytes = 64;
  localparam int unsigned Sets      = 64;
  localparam int unsigned OffW      = $clog2(LineBytes);
  localparam int unsigned IdxW      = $clog2(Sets);
  localparam int unsigned TagW      = AddrBits - OffW - IdxW;

  // Default associativity
  localparam int unsigned Ways      = 4;

  // Result field widths
  localparam int unsigned WayOutW   = 2;
  localparam int unsigned CountW    = 32;

  // Front-to-back queue
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  // One classified access
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [TagW-1:0] tag;
  } salct_req_t;

  // Back-end sequencer
  typedef enum logic {
    BK_READ,
    BK_UPDATE
  } salct_bk_state_e;

endpackage

// ===== rtl/salct_front.sv =====
// ----------------------------------------------------------------------------
// salct_front: access intake
// Splits each address into set index and tag and queues it for the back end.
// ----------------------------------------------------------------------------
module salct_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [salct_pkg::AddrW-1:0] address_i,
  output logic                      req_valid_o,
  input  logic                      req_pop_i,
  output salct_pkg::salct_req_t     req_o
);
  import salct_pkg::*;

  salct_req_t             q_mem [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]         cnt_q, cnt_d;
  logic                   push, pop;
  salct_req_t             req_new;

  // Classify: index just above the line offset, tag above the index
  assign req_new.idx = address_i[OffW +: IdxW];
  assign req_new.tag = address_i[OffW + IdxW +: TagW];

  assign in_ready_o  = (cnt_q != (QPtrW + 1)'(QDepth));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = q_mem[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = req_pop_i && req_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + (QPtrW + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item in the queue slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= req_new;
    end
  end

endmodule

// ===== rtl/salct_back.sv =====
// ----------------------------------------------------------------------------
// salct_back: tag lookup and LRU update
// Reads one set row, compares tags, picks the way, writes the row back and
// presents the result with the running access and miss counts.
// ----------------------------------------------------------------------------
module salct_back #(
  parameter int unsigned WAYS = salct_pkg::Ways
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_pop_o,
  input  salct_pkg::salct_req_t         req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [salct_pkg::WayOutW-1:0] way_o,
  output logic                          evicted_o,
  output logic [salct_pkg::CountW-1:0]  access_count_o,
  output logic [salct_pkg::CountW-1:0]  miss_count_o
);
  import salct_pkg::*;

  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankXW = $clog2(WAYS + 1);

  // Set rows: tags and recency ranks per way
  logic [WAYS-1:0][TagW-1:0]  tag_mem  [Sets];
  logic [WAYS-1:0][RankW-1:0] rank_mem [Sets];
  logic [WAYS-1:0][TagW-1:0]  tag_rd_q;
  logic [WAYS-1:0][RankW-1:0] rank_rd_q;
  logic [Sets-1:0][WAYS-1:0]  valid_q;

  salct_bk_state_e            state_q, state_d;
  logic [IdxW-1:0]            idx_q;
  logic [TagW-1:0]            tag_q;

  logic                       rd_en, commit, out_free;
  logic [WAYS-1:0]            vrow, match;
  logic                       hit, inv_any;
  logic [WayW-1:0]            hit_way, inv_way, vict_way, sel_way;
  logic [RankXW-1:0]          old_rank;
  logic [WAYS-1:0][RankW-1:0] rank_new;
  logic [WAYS-1:0][TagW-1:0]  tag_new;

  logic                       out_valid_q, hit_q, evicted_q;
  logic [WayW-1:0]            way_q;
  logic [CountW-1:0]          acc_q, acc_d, miss_q, miss_d;

  // Sequence: read the set row, then update it
  always_comb begin
    state_d   = state_q;
    req_pop_o = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    case (state_q)
      BK_READ: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          rd_en     = 1'b1;
          state_d   = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = BK_READ;
        end
      end
      default: state_d = BK_READ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_READ;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request and read the set row
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      idx_q     <= req_i.idx;
      tag_q     <= req_i.tag;
      tag_rd_q  <= tag_mem[req_i.idx];
      rank_rd_q <= rank_mem[req_i.idx];
    end
  end

  // Write the updated row back
  always_ff @(posedge clk_i) begin
    if (commit) begin
      tag_mem[idx_q]  <= tag_new;
      rank_mem[idx_q] <= rank_new;
    end
  end

  // Compare tags and locate hit, free and victim ways (lowest way wins)
  assign vrow = valid_q[idx_q];

  always_comb begin
    hit_way  = '0;
    inv_way  = '0;
    vict_way = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      match[k] = vrow[k] && (tag_rd_q[k] == tag_q);
      if (match[k]) begin
        hit_way = WayW'(k);
      end
      if (!vrow[k]) begin
        inv_way = WayW'(k);
      end
      if (rank_rd_q[k] == RankW'(WAYS - 1)) begin
        vict_way = WayW'(k);
      end
    end
    hit     = |match;
    inv_any = ~&vrow;
  end

  // Choose the way and its old rank; an empty way counts as oldest plus one
  always_comb begin
    if (hit) begin
      sel_way  = hit_way;
      old_rank = RankXW'(rank_rd_q[hit_way]);
    end else if (inv_any) begin
      sel_way  = inv_way;
      old_rank = RankXW'(WAYS);
    end else begin
      sel_way  = vict_way;
      old_rank = RankXW'(rank_rd_q[vict_way]);
    end
  end

  // Age every valid way younger than the touched one; touched becomes newest
  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      tag_new[k] = tag_rd_q[k];
      if (WayW'(k) == sel_way) begin
        rank_new[k] = '0;
        tag_new[k]  = tag_q;
      end else if (vrow[k] && (RankXW'(rank_rd_q[k]) < old_rank)) begin
        rank_new[k] = rank_rd_q[k] + RankW'(1);
      end else begin
        rank_new[k] = rank_rd_q[k];
      end
    end
  end

  // Mark lines valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit) begin
      valid_q[idx_q][sel_way] <= 1'b1;
    end
  end

  // Saturating access and miss counters
  always_comb begin
    acc_d  = (acc_q == '1) ? acc_q : acc_q + CountW'(1);
    miss_d = miss_q;
    if (!hit && (miss_q != '1)) begin
      miss_d = miss_q + CountW'(1);
    end
  end

  // Hold the result until taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      miss_q      <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
        miss_q      <= miss_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q     <= hit;
      way_q     <= sel_way;
      evicted_q <= !hit && !inv_any;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign way_o          = WayOutW'((WayW + WayOutW)'(way_q));
  assign evicted_o      = evicted_q;
  assign access_count_o = acc_q;
  assign miss_count_o   = miss_q;

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: set-associative cache tag array with true LRU
// Looks up each address, updates recency and fills or replaces lines.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o | address_i
//  out     | out_valid_o/out_ready_i | hit_o, way_o, evicted_o, access_count_o,
//          |                      | miss_count_o
//
//  In the back end each access first reads the set row from the tag/rank
//  memory in BK_READ, then compares, picks the way and writes the row back
//  in BK_UPDATE, which waits while an untaken result is held at the output.
//  A 2-entry queue keeps the input open while the back end or output stalls.
//  Reset clears the valid bits in flip-flops at once; no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
  parameter int unsigned WAYS = salct_pkg::Ways
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [salct_pkg::AddrW-1:0]   address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [salct_pkg::WayOutW-1:0] way_o,
  output logic                          evicted_o,
  output logic [salct_pkg::CountW-1:0]  access_count_o,
  output logic [salct_pkg::CountW-1:0]  miss_count_o
);
  import salct_pkg::*;

  logic       req_valid, req_pop;
  salct_req_t req;

  salct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .address_i   (address_i),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop),
    .req_o       (req)
  );

  salct_back #(
    .WAYS (WAYS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_pop_o      (req_pop),
    .req_i          (req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .evicted_o      (evicted_o),
    .access_count_o (access_count_o),
    .miss_count_o   (miss_count_o)
  );

endmodule

// ===== rtl/salct_chk.sv =====
// ----------------------------------------------------------------------------
// salct_chk: port-level checks for the LRU tag cache
// Watches the result channel for consistency of hit, eviction and counts.
// ----------------------------------------------------------------------------
module salct_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic [salct_pkg::WayOutW-1:0] way_o,
  input logic                          evicted_o,
  input logic [salct_pkg::CountW-1:0]  access_count_o,
  input logic [salct_pkg::CountW-1:0]  miss_count_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(way_o)
      && $stable(evicted_o) && $stable(access_count_o) && $stable(miss_count_o))
    else $error("result changed while stalled");

  // Eviction happens only on a miss
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("eviction reported on a hit");

  // Misses never outnumber accesses
  a_miss_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> miss_count_o <= access_count_o)
    else $error("miss count above access count");

  // A result counts at least its own access
  a_acc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (access_count_o != '0) && (hit_o || (miss_count_o != '0)))
    else $error("result without a counted access");

endmodule

bind set_assoc_lru_cache_tags salct_chk u_salct_chk (.*);

// ===== bench/set_assoc_lru_cache_tags_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_test: self-checking bench for the LRU tag cache
// Replays an address trace into the cache and checks every lookup against a
// local tag/valid/recency model. The trace is a short directed sequence for
// fills, hits, recency and evictions, then random phases with hot sets and
// small tag pools. Random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_test;
  import salct_pkg::*;

  localparam int unsigned NumWays   = salct_pkg::Ways;
  localparam int unsigned RankW     = $clog2(NumWays);
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned Phases    = 7;
  localparam int unsigned PhaseLen  = 250;

  // One trace entry: address, idle cycles before it, wait for a drained cache
  typedef struct {
    logic [AddrW-1:0] addr;
    int unsigned      gap;
    bit               hold;
  } trace_item_t;

  // One lookup outcome
  typedef struct {
    logic              hit;
    logic [WayOutW-1:0] way;
    logic              evicted;
    logic [CountW-1:0] accesses;
    logic [CountW-1:0] misses;
  } lookup_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [AddrW-1:0]   address_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               hit_o;
  logic [WayOutW-1:0] way_o;
  logic               evicted_o;
  logic [CountW-1:0]  access_count_o;
  logic [CountW-1:0]  miss_count_o;

  // Cache model state
  logic [TagW-1:0]  line_tag   [Sets][NumWays];
  bit               line_valid [Sets][NumWays];
  logic [RankW-1:0] line_rank  [Sets][NumWays];
  logic [CountW-1:0] accesses_seen = '0;
  logic [CountW-1:0] misses_seen   = '0;

  trace_item_t trace_q[$];
  lookup_t     expected_lookups[$];
  int unsigned errors   = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;
  int unsigned idle_cycles = 0;

  set_assoc_lru_cache_tags DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .evicted_o      (evicted_o),
    .access_count_o (access_count_o),
    .miss_count_o   (miss_count_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Look up one address in the model and update tags, valid bits and ranks
  function automatic lookup_t access_line(input logic [AddrW-1:0] addr);
    lookup_t          res;
    logic [IdxW-1:0]  set;
    logic [TagW-1:0]  tag;
    int unsigned      w;
    int unsigned      old_rank;
    bit               found;
    set = addr[OffW +: IdxW];
    tag = addr[AddrW-1 -: TagW];
    res = '{default: '0};
    if (accesses_seen != '1) accesses_seen++;
    found = 1'b0;
    w = 0;
    old_rank = 0;
    for (int k = 0; k < NumWays; k++) begin
      if (!found && line_valid[set][k] && line_tag[set][k] == tag) begin
        w = k;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      old_rank = int'(line_rank[set][w]);
    end else begin
      if (misses_seen != '1) misses_seen++;
      // fill the lowest invalid way first
      for (int k = 0; k < NumWays; k++) begin
        if (!found && !line_valid[set][k]) begin
          w = k;
          found = 1'b1;
        end
      end
      if (found) begin
        old_rank = NumWays;
      end else begin
        // evict the oldest way, lowest index on a tie
        w = 0;
        for (int k = 1; k < NumWays; k++) begin
          if (line_rank[set][k] > line_rank[set][w]) w = k;
        end
        old_rank = int'(line_rank[set][w]);
        res.evicted = 1'b1;
      end
      line_tag[set][w] = tag;
    end
    // age every valid way that was more recent than the touched one
    for (int k = 0; k < NumWays; k++) begin
      if (k != w && line_valid[set][k] && line_rank[set][k] < old_rank) begin
        line_rank[set][k] = line_rank[set][k] + RankW'(1);
      end
    end
    line_rank[set][w]  = '0;
    line_valid[set][w] = 1'b1;
    res.way      = w[WayOutW-1:0];
    res.accesses = accesses_seen;
    res.misses   = misses_seen;
    return res;
  endfunction

  function automatic logic [AddrW-1:0] make_addr(input int unsigned set,
                                                 input logic [TagW-1:0] tag,
                                                 input int unsigned off);
    logic [AddrW-1:0] a;
    a = '0;
    a[AddrW-1 -: TagW] = tag;
    a[OffW +: IdxW]    = set[IdxW-1:0];
    a[OffW-1:0]        = off[OffW-1:0];
    return a;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(input logic [AddrW-1:0] addr, input int unsigned gap,
                           input bit hold);
    trace_item_t it;
    it.addr = addr;
    it.gap  = gap;
    it.hold = hold;
    trace_q.push_back(it);
  endtask

  task automatic report(input string field, input logic [CountW-1:0] exp_v,
                        input logic [CountW-1:0] act_v);
    $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
    errors++;
  endtask

  // Driver: present trace items, predict each accepted access
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic             nxt_valid;
    logic [AddrW-1:0] nxt_addr;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      address_i  <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_addr  = address_i;
      if (in_valid_i && in_ready_o) begin
        expected_lookups.push_back(access_line(address_i));
        nxt_valid = 1'b0;
      end
      // hold valid low through the gap, or until the cache drains
      if (!nxt_valid && trace_q.size() > 0) begin
        if (gap_left < trace_q[0].gap) begin
          gap_left++;
        end else if (!(trace_q[0].hold && expected_lookups.size() > 0)) begin
          nxt_valid = 1'b1;
          nxt_addr  = trace_q[0].addr;
          gap_left  = 0;
          void'(trace_q.pop_front());
        end
      end
      in_valid_i <= nxt_valid;
      address_i  <= nxt_addr;
    end
  end

  // Monitor: check each accepted result, then pick the next ready value
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    lookup_t     exp_r;
    int unsigned r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no access outstanding");
          errors++;
        end else begin
          exp_r = expected_lookups.pop_front();
          if (hit_o !== exp_r.hit)
            report("hit", CountW'(exp_r.hit), CountW'(hit_o));
          if (way_o !== exp_r.way)
            report("way", CountW'(exp_r.way), CountW'(way_o));
          if (evicted_o !== exp_r.evicted)
            report("evicted", CountW'(exp_r.evicted), CountW'(evicted_o));
          if (access_count_o !== exp_r.accesses)
            report("access_count", exp_r.accesses, access_count_o);
          if (miss_count_o !== exp_r.misses)
            report("miss_count", exp_r.misses, miss_count_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
          calm_left--;
        end else if (r < 3) begin
          calm_left = $urandom_range(50, 200);
        end else if (r < 25) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 28) begin
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o === 1'b1 && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Build the trace, run it, wait for the last result
  initial begin
    logic [TagW-1:0] pool [8];
    logic [TagW-1:0] t_a, t_b, t_c, t_d, t_e, t_f;
    int unsigned     n_tags, n_sets, set_base, set_sel, gap;
    bit              no_idle;

    // Directed: extremes of the address, same line twice
    push_item('0, 0, 1'b0);
    push_item({{(AddrW-OffW){1'b0}}, {OffW{1'b1}}}, 0, 1'b0);
    push_item('1, 0, 1'b0);
    push_item(make_addr(Sets-1, '1, 0), 2, 1'b0);
    push_item(32'hAAAA_AAAA, 0, 1'b0);
    push_item(32'h5555_5555, 0, 1'b0);
    // Fill all ways of one set, hit the middle and the newest, then evict
    t_a = 20'h0_0001; t_b = 20'h8_0002; t_c = 20'h7_FFFD; t_d = 20'hF_0F0F;
    t_e = 20'h0_F0F0; t_f = 20'h1_2345;
    push_item(make_addr(5, t_a, 0), 0, 1'b0);
    push_item(make_addr(5, t_b, 1), 0, 1'b0);
    push_item(make_addr(5, t_c, 2), 0, 1'b0);
    push_item(make_addr(5, t_d, 3), 0, 1'b0);
    push_item(make_addr(5, t_b, 63), 0, 1'b0);
    push_item(make_addr(5, t_b, 10), 0, 1'b0);
    push_item(make_addr(5, t_e, 0), 0, 1'b0);
    push_item(make_addr(5, t_c, 0), 1, 1'b0);
    push_item(make_addr(5, t_f, 0), 0, 1'b0);
    push_item(make_addr(5, t_a, 0), 0, 1'b0);
    push_item(make_addr(5, t_d, 0), 0, 1'b0);
    push_item(make_addr(5, t_b, 0), 0, 1'b0);
    // Same tag in another set is a separate line
    push_item(make_addr(6, t_b, 0), 0, 1'b0);
    push_item(make_addr(0, '0, 5), 0, 1'b0);
    push_item(make_addr(0, '1, 5), 0, 1'b1);

    // Random phases: hot sets, small tag pools, some noise
    for (int p = 0; p < Phases; p++) begin
      n_tags = $urandom_range(4, 8);
      for (int i = 0; i < 8; i++) pool[i] = TagW'($urandom());
      if (p == 2) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      case ($urandom_range(0, 3))
        0: n_sets = 1;
        1: n_sets = 2;
        2: n_sets = 4;
        default: n_sets = Sets;
      endcase
      set_base = $urandom_range(0, Sets-1);
      no_idle  = (p == 4);
      for (int i = 0; i < PhaseLen; i++) begin
        gap = no_idle ? 0 : pick_gap();
        if ($urandom_range(0, 99) < 85) begin
          set_sel = (set_base + $urandom_range(0, n_sets-1)) % Sets;
          push_item(make_addr(set_sel, pool[$urandom_range(0, n_tags-1)],
                              $urandom_range(0, LineBytes-1)),
                    gap, (i == 0) && p[0]);
        end else begin
          push_item($urandom(), gap, (i == 0) && p[0]);
        end
      end
    end

    // Reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain
    while (trace_q.size() > 0 || in_valid_i || expected_lookups.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_lookups.size() > 0) begin
      $error("%0d results never arrived", expected_lookups.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/salct_pkg.sv
rtl/salct_front.sv
rtl/salct_back.sv
rtl/set_assoc_lru_cache_tags.sv
rtl/salct_chk.sv
bench/set_assoc_lru_cache_tags_test.sv
